### design/dlm_pkg.sv
package dlm_pkg;

    localparam int POOL_SLOTS = 256;
    localparam int SLOT_W     = $clog2(POOL_SLOTS);
    localparam int COUNT_W    = SLOT_W + 1;

    localparam logic [2:0] CMD_APPEND  = 3'd0;
    localparam logic [2:0] CMD_PREPEND = 3'd1;
    localparam logic [2:0] CMD_INSERT  = 3'd2;
    localparam logic [2:0] CMD_MOVE    = 3'd3;
    localparam logic [2:0] CMD_REMOVE  = 3'd4;

    // one link: valid flag and slot
    typedef struct packed {
        logic              ok;
        logic [SLOT_W-1:0] at;
    } t_link;

    localparam int LINK_W = $bits(t_link);

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] node_slot;
        logic [7:0] anchor_slot;
        logic       anchor_absent;
    } t_in_item;

    typedef struct packed {
        logic [7:0] head_slot;
        logic       head_valid;
        logic [7:0] tail_slot;
        logic       tail_valid;
        logic [8:0] length;
    } t_out_item;

    function automatic t_link mk_link(input logic [SLOT_W-1:0] slot);
        t_link l;
        l.ok = 1'b1;
        l.at = slot;
        return l;
    endfunction

    function automatic t_link nil_link();
        t_link l;
        l.ok = 1'b0;
        l.at = '0;
        return l;
    endfunction

endpackage

### design/dlm_ram.sv
module dlm_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/doubly_linked_list_manager.sv
// channel   direction  handshake              payload
// command   in         i_valid / o_ready      i_data  (dlm_pkg::t_in_item)
// result    out        o_valid / i_ready      o_data  (dlm_pkg::t_out_item)
//
// commands are worked one at a time (o_ready only in idle); an unused code changes
// nothing but still returns a result; one result item per command item
// each link memory has a single write port, one link rewrite per cycle
// reset (synchronous, active low) empties the list; link memories are not cleared
// a new command is taken while the previous result still waits in o_data;
// a held result stalls only the end of the following command
module doubly_linked_list_manager (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  dlm_pkg::t_in_item  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output dlm_pkg::t_out_item o_data
);
    import dlm_pkg::*;

    // sequencer steps
    typedef enum logic [2:0] {
        S_IDLE,    // wait for a command, read links of the node (or anchor)
        S_ENDS1,   // append / prepend: link to the old end
        S_ENDS2,   // append / prepend: null the outer link, move the end pointer
        S_UNLINK,  // move / remove: bypass the node
        S_SPLICE,  // insert / move: hook node behind anchor or at the front
        S_CLOSE,   // insert / move: hook node in front of its successor
        S_CLEAR,   // remove: null both links of the node
        S_DONE     // hand the result to the output register
    } t_state;

    t_state            r_state, n_state;
    logic [2:0]        r_cmd, n_cmd;
    logic [SLOT_W-1:0] r_node, n_node;
    logic [SLOT_W-1:0] r_anchor, n_anchor;
    logic              r_has_anchor, n_has_anchor;
    t_link             r_head, n_head;
    t_link             r_tail, n_tail;
    logic [COUNT_W-1:0] r_count, n_count;
    t_link             r_after, n_after;
    logic              r_fwd_hit, n_fwd_hit;
    t_link             r_fwd_data, n_fwd_data;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;

    // link memory ports
    logic              prev_we, next_we;
    logic [SLOT_W-1:0] prev_waddr, next_waddr;
    t_link             prev_wdata, next_wdata;
    logic [SLOT_W-1:0] prev_raddr, next_raddr;
    logic [LINK_W-1:0] prev_rbits, next_rbits;
    t_link             prev_rd, next_rd;
    t_link             next_seen;
    t_link             after_val;

    dlm_ram #(.WIDTH(LINK_W), .DEPTH(POOL_SLOTS)) u_prev_ram (
        .i_clk  (i_clk),
        .i_we   (prev_we),
        .i_waddr(prev_waddr),
        .i_wdata(prev_wdata),
        .i_raddr(prev_raddr),
        .o_rdata(prev_rbits)
    );

    dlm_ram #(.WIDTH(LINK_W), .DEPTH(POOL_SLOTS)) u_next_ram (
        .i_clk  (i_clk),
        .i_we   (next_we),
        .i_waddr(next_waddr),
        .i_wdata(next_wdata),
        .i_raddr(next_raddr),
        .o_rdata(next_rbits)
    );

    assign prev_rd = t_link'(prev_rbits);
    assign next_rd = t_link'(next_rbits);

    // the anchor's next link is read while unlink writes the next memory;
    // a same-address write is forwarded past the read-old ram
    assign next_seen = r_fwd_hit ? r_fwd_data : next_rd;
    assign after_val = r_has_anchor ? next_seen : r_head;

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_node       = r_node;
        n_anchor     = r_anchor;
        n_has_anchor = r_has_anchor;
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_after      = r_after;
        n_out_valid  = r_out_valid;
        n_out        = r_out;

        prev_we    = 1'b0;
        prev_waddr = r_node;
        prev_wdata = nil_link();
        next_we    = 1'b0;
        next_waddr = r_node;
        next_wdata = nil_link();

        // in idle both links of the node are read; insert reads the anchor's next
        prev_raddr = i_data.node_slot[SLOT_W-1:0];
        next_raddr = (i_data.cmd == CMD_INSERT) ? i_data.anchor_slot[SLOT_W-1:0]
                                                : i_data.node_slot[SLOT_W-1:0];

        // result taken downstream
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd        = i_data.cmd;
                    n_node       = i_data.node_slot[SLOT_W-1:0];
                    n_anchor     = i_data.anchor_slot[SLOT_W-1:0];
                    n_has_anchor = ~i_data.anchor_absent;
                    case (i_data.cmd)
                        CMD_APPEND, CMD_PREPEND: n_state = S_ENDS1;
                        CMD_INSERT:              n_state = S_SPLICE;
                        CMD_MOVE, CMD_REMOVE:    n_state = S_UNLINK;
                        default:                 n_state = S_DONE;
                    endcase
                end
            end

            S_ENDS1: begin
                if (r_cmd == CMD_APPEND) begin
                    if (r_tail.ok) begin
                        next_we    = 1'b1;
                        next_waddr = r_tail.at;
                        next_wdata = mk_link(r_node);
                    end else begin
                        n_head = mk_link(r_node);
                    end
                    prev_we    = 1'b1;
                    prev_waddr = r_node;
                    prev_wdata = r_tail;
                end else begin
                    if (r_head.ok) begin
                        prev_we    = 1'b1;
                        prev_waddr = r_head.at;
                        prev_wdata = mk_link(r_node);
                    end else begin
                        n_tail = mk_link(r_node);
                    end
                    next_we    = 1'b1;
                    next_waddr = r_node;
                    next_wdata = r_head;
                end
                n_state = S_ENDS2;
            end

            S_ENDS2: begin
                // outer link of the new node goes null after any aliased write
                if (r_cmd == CMD_APPEND) begin
                    next_we    = 1'b1;
                    next_waddr = r_node;
                    next_wdata = nil_link();
                    n_tail     = mk_link(r_node);
                end else begin
                    prev_we    = 1'b1;
                    prev_waddr = r_node;
                    prev_wdata = nil_link();
                    n_head     = mk_link(r_node);
                end
                n_count = r_count + COUNT_W'(1);
                n_state = S_DONE;
            end

            S_UNLINK: begin
                // prev_rd / next_rd hold the node's own links
                if (r_head.ok && r_head.at == r_node) begin
                    n_head = next_rd;
                end
                if (r_tail.ok && r_tail.at == r_node) begin
                    n_tail = prev_rd;
                end
                if (next_rd.ok) begin
                    prev_we    = 1'b1;
                    prev_waddr = next_rd.at;
                    prev_wdata = prev_rd;
                end
                if (prev_rd.ok) begin
                    next_we    = 1'b1;
                    next_waddr = prev_rd.at;
                    next_wdata = next_rd;
                end
                next_raddr = r_anchor;
                n_state = (r_cmd == CMD_MOVE) ? S_SPLICE : S_CLEAR;
            end

            S_SPLICE: begin
                n_after = after_val;
                if (r_has_anchor) begin
                    next_we    = 1'b1;
                    next_waddr = r_anchor;
                    next_wdata = mk_link(r_node);
                    prev_we    = 1'b1;
                    prev_waddr = r_node;
                    prev_wdata = mk_link(r_anchor);
                end else begin
                    prev_we    = 1'b1;
                    prev_waddr = r_node;
                    prev_wdata = nil_link();
                    n_head     = mk_link(r_node);
                end
                n_state = S_CLOSE;
            end

            S_CLOSE: begin
                next_we    = 1'b1;
                next_waddr = r_node;
                next_wdata = r_after;
                if (!r_after.ok) begin
                    n_tail = mk_link(r_node);
                end else begin
                    prev_we    = 1'b1;
                    prev_waddr = r_after.at;
                    prev_wdata = mk_link(r_node);
                end
                // move keeps the count
                if (r_cmd == CMD_INSERT) begin
                    n_count = r_count + COUNT_W'(1);
                end
                n_state = S_DONE;
            end

            S_CLEAR: begin
                next_we    = 1'b1;
                next_waddr = r_node;
                next_wdata = nil_link();
                prev_we    = 1'b1;
                prev_waddr = r_node;
                prev_wdata = nil_link();
                n_count    = r_count - COUNT_W'(1);
                n_state    = S_DONE;
            end

            S_DONE: begin
                // wait here only while the previous result is still held
                if (!r_out_valid || i_ready) begin
                    n_out.head_slot  = r_head.ok ? 8'(r_head.at) : 8'd0;
                    n_out.head_valid = r_head.ok;
                    n_out.tail_slot  = r_tail.ok ? 8'(r_tail.at) : 8'd0;
                    n_out.tail_valid = r_tail.ok;
                    n_out.length     = 9'(r_count);
                    n_out_valid      = 1'b1;
                    n_state          = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase

        n_fwd_hit  = next_we && (next_waddr == next_raddr);
        n_fwd_data = next_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= nil_link();
            r_tail      <= nil_link();
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_fwd_hit   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_fwd_hit   <= n_fwd_hit;
        end
        r_cmd        <= n_cmd;
        r_node       <= n_node;
        r_anchor     <= n_anchor;
        r_has_anchor <= n_has_anchor;
        r_after      <= n_after;
        r_fwd_data   <= n_fwd_data;
        r_out        <= n_out;
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

### design/dlm_checker.sv
module dlm_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input dlm_pkg::t_in_item  i_data,
    input logic               o_valid,
    input logic               i_ready,
    input dlm_pkg::t_out_item o_data
);
    import dlm_pkg::*;

    // held result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result item changed while stalled");

    // after reset: idle and empty handed out
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("not idle after reset");

    // one command at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second item taken before the first finished");

    // absent ends report slot zero
    a_null_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.head_valid || o_data.head_slot == 8'd0) &&
                    (o_data.tail_valid || o_data.tail_slot == 8'd0))
        else $error("absent end with nonzero slot");

endmodule

bind doubly_linked_list_manager dlm_checker u_dlm_checker (.*);
